// ----- sv/ccs_pkg.sv -----
package ccs_pkg;

   // lexical modes
   typedef enum logic [2:0] {
      MODE_CODE  = 3'd0,
      MODE_LINE  = 3'd1,
      MODE_BLOCK = 3'd2,
      MODE_DQ    = 3'd3,
      MODE_SQ    = 3'd4
   } lex_mode_type;

   // characters the lexer reacts to
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;

   // queue between lexer and output serializer
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // one or two output bytes caused by one input item
   typedef struct packed {
      logic       two;
      logic [7:0] first;
      logic [7:0] second;
   } entry_type;

endpackage

// ----- sv/ccs_front.sv -----
module ccs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         in_byte,
   input  logic               in_last,
   output logic               enq_valid,
   output ccs_pkg::entry_type enq_entry
);
   import ccs_pkg::*;

   lex_mode_type mode_ff, mode_in;
   logic held_ff, held_in;
   logic star_ff, star_in;
   logic esc_ff, esc_in;

   logic [1:0] cnt;
   logic [7:0] b0, b1;
   logic [7:0] quote;

   // lexer next state and emitted bytes
   always_comb begin
      mode_in = mode_ff;
      held_in = held_ff;
      star_in = star_ff;
      esc_in  = esc_ff;
      cnt     = 2'd0;
      b0      = in_byte;
      b1      = in_byte;
      quote   = (mode_ff == MODE_SQ) ? CH_SQUOTE : CH_DQUOTE;
      unique case (mode_ff)
         MODE_LINE: begin
            if (in_byte == CH_NL) begin
               mode_in = MODE_CODE;
               cnt     = 2'd1;
            end
         end
         MODE_BLOCK: begin
            if (star_ff && in_byte == CH_SLASH) begin
               mode_in = MODE_CODE;
               star_in = 1'b0;
            end else begin
               star_in = (in_byte == CH_STAR);
            end
         end
         MODE_DQ, MODE_SQ: begin
            if (esc_ff) begin
               esc_in = 1'b0;
            end else if (in_byte == CH_BSLASH) begin
               esc_in = 1'b1;
            end else if (in_byte == quote) begin
               mode_in = MODE_CODE;
            end
            cnt = 2'd1;
         end
         default: begin
            mode_in = MODE_CODE;
            if (held_ff) begin
               held_in = 1'b0;
               if (in_byte == CH_SLASH) begin
                  mode_in = MODE_LINE;
               end else if (in_byte == CH_STAR) begin
                  mode_in = MODE_BLOCK;
                  star_in = 1'b0;
               end else begin
                  // slash was not a comment opener: emit it ahead of the byte
                  cnt = 2'd2;
                  b0  = CH_SLASH;
                  if (in_byte == CH_DQUOTE) begin
                     mode_in = MODE_DQ;
                     esc_in  = 1'b0;
                  end else if (in_byte == CH_SQUOTE) begin
                     mode_in = MODE_SQ;
                     esc_in  = 1'b0;
                  end
               end
            end else begin
               if (in_byte == CH_SLASH) begin
                  held_in = 1'b1;
               end else begin
                  cnt = 2'd1;
                  if (in_byte == CH_DQUOTE) begin
                     mode_in = MODE_DQ;
                     esc_in  = 1'b0;
                  end else if (in_byte == CH_SQUOTE) begin
                     mode_in = MODE_SQ;
                     esc_in  = 1'b0;
                  end
               end
            end
         end
      endcase
      // end of stream: flush a held slash, then start fresh
      if (in_last) begin
         if (held_in) begin
            cnt = 2'd1;
            b0  = CH_SLASH;
         end
         mode_in = MODE_CODE;
         held_in = 1'b0;
         star_in = 1'b0;
         esc_in  = 1'b0;
      end
   end

   // lexer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CODE;
         held_ff <= 1'b0;
         star_ff <= 1'b0;
         esc_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         held_ff <= held_in;
         star_ff <= star_in;
         esc_ff  <= esc_in;
      end
   end

   // items that emit nothing never enter the queue
   assign enq_valid        = accept && (cnt != 2'd0);
   assign enq_entry.two    = (cnt == 2'd2);
   assign enq_entry.first  = b0;
   assign enq_entry.second = b1;

endmodule

// ----- sv/ccs_queue.sv -----
module ccs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               enq_valid,
   input  ccs_pkg::entry_type enq_entry,
   output logic               full,
   input  logic               deq_ready,
   output logic               empty,
   output ccs_pkg::entry_type head
);
   import ccs_pkg::*;

   entry_type entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;
   logic do_enq, do_deq;

   assign full   = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign head   = entries_ff[rd_ptr_ff];
   assign do_enq = enq_valid && !full;
   assign do_deq = deq_ready && !empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_enq ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_deq ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_enq && !do_deq) begin
         count_in = count_ff + 1'b1;
      end else if (do_deq && !do_enq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_enq) begin
         entries_ff[wr_ptr_ff] <= enq_entry;
      end
   end

   // fill count never exceeds the depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CW'(QUEUE_DEPTH))
      else $error("queue count out of range");

   // fill count tracks the pointers
   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QUEUE_CW'(QUEUE_DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");

   // a lone dequeue lowers the count by one
   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      (do_deq && !do_enq) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count not decremented");

endmodule

// ----- sv/ccs_back.sv -----
module ccs_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  ccs_pkg::entry_type head,
   output logic               deq_ready,
   input  logic               pop,
   output logic [7:0]         out_byte,
   output logic               out_last
);
   import ccs_pkg::*;

   logic sel_ff, sel_in;
   logic take;

   assign take      = pop && !empty;
   assign out_byte  = sel_ff ? head.second : head.first;
   assign out_last  = sel_ff || !head.two;
   assign deq_ready = take && out_last;

   // second byte of a two-byte entry
   always_comb begin
      sel_in = sel_ff;
      if (take) begin
         sel_in = !out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

endmodule

// ----- sv/c_comment_stripper.sv -----
// Streaming C comment stripper. Source bytes enter on req_in_byte with push and
// leave on rsp_out_byte through a queue-style result port (empty/pop); line and
// block comments are removed, literals with backslash escapes pass untouched, and
// req_in_last flushes a held slash and restarts the lexer for a new stream. One
// byte is accepted every cycle while full is low. The lexer is a state machine that
// writes each byte's results, one or two bytes, into a four-entry queue; a result
// is in the queue from the cycle after its byte is accepted. A byte that yields
// two results (a slash that turned out not to open a comment, plus the byte itself)
// takes two pops but one entry, so full rises only when four entries wait unpopped.
// rsp_out_last marks the final result caused by one input byte.
module c_comment_stripper (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);
   import ccs_pkg::*;

   logic      accept;
   logic      enq_valid;
   entry_type enq_entry;
   logic      deq_ready;
   entry_type head;

   assign accept = push && !full;

   // lexer
   ccs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .in_last   (req_in_last),
      .enq_valid (enq_valid),
      .enq_entry (enq_entry)
   );

   // decoupling queue
   ccs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .enq_valid (enq_valid),
      .enq_entry (enq_entry),
      .full      (full),
      .deq_ready (deq_ready),
      .empty     (empty),
      .head      (head)
   );

   // output serializer
   ccs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head      (head),
      .deq_ready (deq_ready),
      .pop       (pop),
      .out_byte  (rsp_out_byte),
      .out_last  (rsp_out_last)
   );

endmodule
